// ----- src/rgb_luma_histogram_defines.svh -----
// Assertion macros shared by the histogram RTL.
`ifndef RGB_LUMA_HISTOGRAM_DEFINES_SVH
`define RGB_LUMA_HISTOGRAM_DEFINES_SVH
`ifndef ASSERT_OFF
`define RLH_ASSERT(label, expr) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (expr)) \
	else $error("assertion failed");
`define RLH_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error("assertion failed");
`define RLH_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error("assertion failed");
`else
`define RLH_ASSERT(label, expr)
`define RLH_ASSERT_IMP(label, ante, cons)
`define RLH_ASSERT_NXT(label, ante, cons)
`endif
`endif

// ----- src/rlh_pkg.sv -----
// Types and constants of the RGB and luma histogram.
package rlh_pkg;

	localparam int LANES       = 4;
	localparam int OUT_COUNT_W = 24;
	localparam int HEIGHT_W    = 10;
	localparam int SCALE_W     = 10;
	localparam int ADDR_W      = 3;
	localparam int LUMA_SUM_W  = 24;

	localparam logic [15:0] LUMA_WR = 16'd13933;
	localparam logic [15:0] LUMA_WG = 16'd46871;
	localparam logic [15:0] LUMA_WB = 16'd4732;

	localparam logic [SCALE_W-1:0]     SCALE_RESET   = 10'd200;
	localparam logic [OUT_COUNT_W-1:0] OUT_COUNT_MAX = 24'hFFFFFF;

	localparam logic [1:0] OP_ADD   = 2'd0;
	localparam logic [1:0] OP_READ  = 2'd1;
	localparam logic [1:0] OP_CLEAR = 2'd2;

	localparam logic [0:0] REG_BAR_SCALE = 1'd0;

	typedef struct packed {
		logic [7:0] bin;
		logic [7:0] blue;
		logic [7:0] green;
		logic [7:0] red;
	} rlh_pixel_t;

	typedef struct packed {
		logic [7:0]             pixel_luma;
		logic [HEIGHT_W-1:0]    luma_height;
		logic [HEIGHT_W-1:0]    blue_height;
		logic [HEIGHT_W-1:0]    green_height;
		logic [HEIGHT_W-1:0]    red_height;
		logic [OUT_COUNT_W-1:0] luma_count;
		logic [OUT_COUNT_W-1:0] blue_count;
		logic [OUT_COUNT_W-1:0] green_count;
		logic [OUT_COUNT_W-1:0] red_count;
	} rlh_result_t;

	function automatic logic [OUT_COUNT_W-1:0] clip_count(input logic [31:0] value);
		logic [OUT_COUNT_W-1:0] res;
		if (value > 32'(OUT_COUNT_MAX)) begin
			res = OUT_COUNT_MAX;
		end else begin
			res = value[OUT_COUNT_W-1:0];
		end
		return res;
	endfunction

endpackage

// ----- src/rgb_luma_histogram.sv -----
// Four-channel pixel histogram with bar heights, held in block memories.
// An add pixel beat passes ST_LUMA and ST_RMW, a read bin beat ST_READ, ST_RDATA and the
// bit-per-cycle restoring divider in ST_DIV; a clear or unused beat goes to ST_DONE at once.
// Each result waits in ST_DONE through any output stall. One beat is worked at a time.
// After reset and after each clear a sweep zeroes all BIN_COUNT (256) bins, and no beat is
// accepted during it; configuration writes are always taken.
`include "rgb_luma_histogram_defines.svh"

module rgb_luma_histogram #(
	parameter int COUNT_WIDTH = 24,
	parameter int BIN_COUNT   = 256
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      psel,
	input  logic                      penable,
	input  logic                      pwrite,
	input  logic [rlh_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]               pwdata,
	output logic [31:0]               prdata,
	output logic                      pready,
	input  logic                      s_tvalid,
	output logic                      s_tready,
	// Fields from bit 0: red, green, blue, bin.
	input  rlh_pkg::rlh_pixel_t       s_tdata,
	// Fields from bit 0: opcode.
	input  logic [1:0]                s_tuser,
	output logic                      m_tvalid,
	input  logic                      m_tready,
	// Fields from bit 0: red_count, green_count, blue_count, luma_count, red_height,
	// green_height, blue_height, luma_height, pixel_luma.
	output rlh_pkg::rlh_result_t      m_tdata
);
	import rlh_pkg::*;

	localparam int BIN_W = $clog2(BIN_COUNT);
	localparam int NUM_W = COUNT_WIDTH + SCALE_W;
	localparam int DCNT_W = $clog2(HEIGHT_W);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_LUMA  = 3'd1;
	localparam logic [2:0] ST_RMW   = 3'd2;
	localparam logic [2:0] ST_READ  = 3'd3;
	localparam logic [2:0] ST_RDATA = 3'd4;
	localparam logic [2:0] ST_DIV   = 3'd5;
	localparam logic [2:0] ST_DONE  = 3'd6;
	localparam logic [2:0] ST_CLEAR = 3'd7;

	logic [2:0]             state_q;
	logic [1:0]             op_q;
	logic [BIN_W-1:0]       clr_addr_q;
	logic [DCNT_W-1:0]      div_cnt_q;
	logic [SCALE_W-1:0]     scale_q;
	logic [LUMA_SUM_W-1:0]  prod_r_q, prod_g_q, prod_b_q;
	logic [LUMA_SUM_W-1:0]  luma_sum;
	logic [7:0]             luma_byte;
	logic [BIN_W-1:0]       idx_q   [LANES];
	logic [COUNT_WIDTH-1:0] max_q   [LANES];
	logic [COUNT_WIDTH-1:0] rd_data [LANES];
	logic [COUNT_WIDTH-1:0] inc     [LANES];
	logic [BIN_W-1:0]       raddr   [LANES];
	logic [NUM_W-1:0]       rem_q   [LANES];
	logic [NUM_W-1:0]       dvs_q   [LANES];
	logic [NUM_W-1:0]       rem_nxt [LANES];
	logic [HEIGHT_W-1:0]    quo_q   [LANES];
	logic [HEIGHT_W-1:0]    quo_nxt [LANES];
	logic [LANES-1:0]       ge;
	logic [LANES-1:0]       mz_q;
	logic                   mem_we;
	logic                   cfg_hit;
	logic                   out_load;
	rlh_result_t            res_q;
	rlh_result_t            out_q;
	logic                   out_valid_q;

	assign pready   = 1'b1;
	assign cfg_hit  = (paddr[ADDR_W-1:2] == REG_BAR_SCALE);
	assign prdata   = cfg_hit ? 32'(scale_q) : 32'd0;
	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_q;
	assign out_load = (state_q == ST_DONE) && (!out_valid_q || m_tready);

	assign luma_sum  = prod_r_q + prod_g_q + prod_b_q;
	assign luma_byte = luma_sum[LUMA_SUM_W-1 -: 8];
	assign mem_we    = (state_q == ST_RMW) || (state_q == ST_CLEAR);

	always_comb begin
		for (int l = 0; l < LANES; l++) begin
			raddr[l] = idx_q[l];
			inc[l]   = (rd_data[l] == {COUNT_WIDTH{1'b1}}) ? rd_data[l]
				: rd_data[l] + COUNT_WIDTH'(1);
			ge[l]      = (rem_q[l] >= dvs_q[l]);
			rem_nxt[l] = ge[l] ? rem_q[l] - dvs_q[l] : rem_q[l];
			quo_nxt[l] = {quo_q[l][HEIGHT_W-2:0], ge[l]};
		end
		if (state_q == ST_LUMA) begin
			raddr[LANES-1] = luma_byte[BIN_W-1:0];
		end
	end

	for (genvar l = 0; l < LANES; l++) begin : g_lane
		logic [COUNT_WIDTH-1:0] mem [BIN_COUNT];
		logic [COUNT_WIDTH-1:0] rd_q;

		always_ff @(posedge clk) begin
			if (mem_we) begin
				if (state_q == ST_CLEAR) begin
					mem[clr_addr_q] <= '0;
				end else begin
					mem[idx_q[l]] <= inc[l];
				end
			end
			rd_q <= mem[raddr[l]];
		end

		assign rd_data[l] = rd_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_q <= SCALE_RESET;
		end else if (psel && penable && pwrite && cfg_hit) begin
			scale_q <= pwdata[SCALE_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_addr_q  <= '0;
			div_cnt_q   <= '0;
			out_valid_q <= 1'b0;
			for (int l = 0; l < LANES; l++) begin
				max_q[l] <= '0;
			end
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						op_q     <= s_tuser;
						res_q    <= '0;
						prod_r_q <= LUMA_SUM_W'(LUMA_WR) * LUMA_SUM_W'(s_tdata.red);
						prod_g_q <= LUMA_SUM_W'(LUMA_WG) * LUMA_SUM_W'(s_tdata.green);
						prod_b_q <= LUMA_SUM_W'(LUMA_WB) * LUMA_SUM_W'(s_tdata.blue);
						if (s_tuser == OP_READ) begin
							for (int l = 0; l < LANES; l++) begin
								idx_q[l] <= s_tdata.bin[BIN_W-1:0];
							end
							state_q <= ST_READ;
						end else if (s_tuser == OP_ADD) begin
							idx_q[0] <= s_tdata.red[BIN_W-1:0];
							idx_q[1] <= s_tdata.green[BIN_W-1:0];
							idx_q[2] <= s_tdata.blue[BIN_W-1:0];
							state_q  <= ST_LUMA;
						end else begin
							state_q <= ST_DONE;
						end
					end
				end
				ST_LUMA: begin
					idx_q[LANES-1] <= luma_byte[BIN_W-1:0];
					res_q.pixel_luma <= luma_byte;
					state_q <= ST_RMW;
				end
				ST_RMW: begin
					for (int l = 0; l < LANES; l++) begin
						if (inc[l] > max_q[l]) begin
							max_q[l] <= inc[l];
						end
					end
					state_q <= ST_DONE;
				end
				ST_READ: begin
					state_q <= ST_RDATA;
				end
				ST_RDATA: begin
					res_q.red_count   <= clip_count(32'(rd_data[0]));
					res_q.green_count <= clip_count(32'(rd_data[1]));
					res_q.blue_count  <= clip_count(32'(rd_data[2]));
					res_q.luma_count  <= clip_count(32'(rd_data[3]));
					for (int l = 0; l < LANES; l++) begin
						rem_q[l] <= NUM_W'(rd_data[l]) * NUM_W'(scale_q);
						dvs_q[l] <= NUM_W'(max_q[l]) << (HEIGHT_W - 1);
						quo_q[l] <= '0;
						mz_q[l]  <= (max_q[l] == '0);
					end
					div_cnt_q <= '0;
					state_q   <= ST_DIV;
				end
				ST_DIV: begin
					for (int l = 0; l < LANES; l++) begin
						rem_q[l] <= rem_nxt[l];
						dvs_q[l] <= dvs_q[l] >> 1;
						quo_q[l] <= quo_nxt[l];
					end
					div_cnt_q <= div_cnt_q + DCNT_W'(1);
					if (div_cnt_q == DCNT_W'(HEIGHT_W - 1)) begin
						res_q.red_height   <= mz_q[0] ? '0 : quo_nxt[0];
						res_q.green_height <= mz_q[1] ? '0 : quo_nxt[1];
						res_q.blue_height  <= mz_q[2] ? '0 : quo_nxt[2];
						res_q.luma_height  <= mz_q[3] ? '0 : quo_nxt[3];
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_load) begin
						out_q   <= res_q;
						state_q <= (op_q == OP_CLEAR) ? ST_CLEAR : ST_IDLE;
					end
				end
				ST_CLEAR: begin
					for (int l = 0; l < LANES; l++) begin
						max_q[l] <= '0;
					end
					clr_addr_q <= clr_addr_q + BIN_W'(1);
					if (clr_addr_q == BIN_W'(BIN_COUNT - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	`RLH_ASSERT_IMP(a_count_within_max, state_q == ST_RDATA,
		rd_data[0] <= max_q[0] && rd_data[1] <= max_q[1] &&
		rd_data[2] <= max_q[2] && rd_data[3] <= max_q[3])
	`RLH_ASSERT_IMP(a_height_within_scale, m_tvalid,
		m_tdata.red_height <= scale_q && m_tdata.green_height <= scale_q &&
		m_tdata.blue_height <= scale_q && m_tdata.luma_height <= scale_q)
	`RLH_ASSERT_IMP(a_sweep_rewound, state_q == ST_IDLE, clr_addr_q == '0)
	`RLH_ASSERT_NXT(a_beat_starts_work, s_tvalid && s_tready, state_q != ST_IDLE)

endmodule
